FILE: src/scd_pkg.sv
// Shared types and constants for the stuck condition detector.
package scd_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DirW    = 3;
  localparam int unsigned LimitW  = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InTdataW  = 120;
  localparam int unsigned OutTdataW = 8;

  // Change reported when a sector reading appears or disappears.
  localparam logic [DistW-1:0] SectorGoneDelta = DistW'(10000);
  localparam logic [2:0]       BoxedCount      = 3'd3;

  typedef enum logic [DirW-1:0] {
    DIR_IDLE  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_ARC_L = 3'd2,
    DIR_ARC_R = 3'd3,
    DIR_REV   = 3'd4,
    DIR_SPIN_L = 3'd5,
    DIR_SPIN_R = 3'd6,
    DIR_OTHER = 3'd7
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEAR_FRONT    = 3'd0,
    REG_NEAR_REAR     = 3'd1,
    REG_NEAR_SIDE     = 3'd2,
    REG_CHANGE_LIMIT  = 3'd3,
    REG_DETECT_WINDOW = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DistW-1:0]  near_front_mm;
    logic [DistW-1:0]  near_rear_mm;
    logic [DistW-1:0]  near_side_mm;
    logic [LimitW-1:0] change_limit_mm;
    logic [DistW-1:0]  detect_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [DistW-1:0] right_nearest_mm;
    logic [DistW-1:0] left_nearest_mm;
    logic [DistW-1:0] rear_nearest_mm;
    logic [DistW-1:0] contact_nearest_mm;
    logic [DistW-1:0] front_nearest_mm;
    logic [DirW-1:0]  drive_dir;
    logic             auto_mode;
    logic             scan_fresh;
  } scan_t;

  typedef struct packed {
    logic             armed;
    logic [DirW-1:0]  base_dir;
    logic [TimeW-1:0] base_time;
    logic [DistW-1:0] base_front;
    logic [DistW-1:0] base_rear;
    logic [DistW-1:0] base_left;
    logic [DistW-1:0] base_right;
  } base_t;

  typedef struct packed {
    logic surrounded;
    logic start_escape;
  } result_t;

  localparam base_t BaseReset = '0;

endpackage

FILE: src/scd_cfg.sv
// Configuration register file of the stuck condition detector.
module scd_cfg
  import scd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_front_mm    <= DistW'(250);
      cfg.near_rear_mm     <= DistW'(200);
      cfg.near_side_mm     <= DistW'(150);
      cfg.change_limit_mm  <= LimitW'(40);
      cfg.detect_window_ms <= DistW'(1200);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NEAR_FRONT:    cfg.near_front_mm    <= cfg_data;
        REG_NEAR_REAR:     cfg.near_rear_mm     <= cfg_data;
        REG_NEAR_SIDE:     cfg.near_side_mm     <= cfg_data;
        REG_CHANGE_LIMIT:  cfg.change_limit_mm  <= cfg_data[LimitW-1:0];
        REG_DETECT_WINDOW: cfg.detect_window_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/scd_eval.sv
// Per-scan decision logic: next baseline and result from one scan.
module scd_eval
  import scd_pkg::*;
(
  input  cfg_t    cfg,
  input  scan_t   scan,
  input  base_t   base,
  output base_t   base_next,
  output result_t result
);

  function automatic logic is_near(input logic [DistW-1:0] d, input logic [DistW-1:0] lim);
    is_near = (d != '0) && (d <= lim);
  endfunction

  function automatic logic small_change(input logic [DistW-1:0] cur,
                                        input logic [DistW-1:0] ref_d,
                                        input logic [LimitW-1:0] lim);
    logic [DistW-1:0] delta;
    if (cur == '0 && ref_d == '0) begin
      delta = '0;
    end else if (cur == '0 || ref_d == '0) begin
      delta = SectorGoneDelta;
    end else if (cur > ref_d) begin
      delta = cur - ref_d;
    end else begin
      delta = ref_d - cur;
    end
    small_change = delta <= {{(DistW-LimitW){1'b0}}, lim};
  endfunction

  logic [DistW-1:0] front;
  logic             fn, rn, ln, rtn, push, still, boxed, aged, active;
  logic [2:0]       cnt;
  logic [TimeW-1:0] age;
  base_t            fresh_base;

  always_comb begin
    // A zero front reading falls back to the close-contact sensor.
    front = (scan.front_nearest_mm != '0) ? scan.front_nearest_mm
                                          : scan.contact_nearest_mm;
    fn  = is_near(front, cfg.near_front_mm);
    rn  = is_near(scan.rear_nearest_mm, cfg.near_rear_mm);
    ln  = is_near(scan.left_nearest_mm, cfg.near_side_mm);
    rtn = is_near(scan.right_nearest_mm, cfg.near_side_mm);
    cnt = {2'b00, fn} + {2'b00, rn} + {2'b00, ln} + {2'b00, rtn};
    boxed = cnt >= BoxedCount;

    age  = scan.now_ms - base.base_time;
    aged = age >= {{(TimeW-DistW){1'b0}}, cfg.detect_window_ms};

    case (dir_t'(scan.drive_dir))
      DIR_FWD, DIR_ARC_L, DIR_ARC_R: push = fn;
      DIR_REV:                       push = rn;
      default:                       push = 1'b0;
    endcase

    still = small_change(front, base.base_front, cfg.change_limit_mm) &&
            small_change(scan.rear_nearest_mm, base.base_rear, cfg.change_limit_mm) &&
            small_change(scan.left_nearest_mm, base.base_left, cfg.change_limit_mm) &&
            small_change(scan.right_nearest_mm, base.base_right, cfg.change_limit_mm);

    active = scan.scan_fresh && scan.auto_mode && (scan.drive_dir != DIR_IDLE);

    fresh_base.armed      = 1'b1;
    fresh_base.base_dir   = scan.drive_dir;
    fresh_base.base_time  = scan.now_ms;
    fresh_base.base_front = front;
    fresh_base.base_rear  = scan.rear_nearest_mm;
    fresh_base.base_left  = scan.left_nearest_mm;
    fresh_base.base_right = scan.right_nearest_mm;

    result = '0;
    if (!active) begin
      base_next = BaseReset;
    end else if (!base.armed || base.base_dir != scan.drive_dir) begin
      base_next = fresh_base;
    end else if (!aged) begin
      base_next = base;
    end else if (boxed || (push && still)) begin
      result.start_escape = 1'b1;
      result.surrounded   = boxed;
      base_next           = BaseReset;
    end else begin
      base_next = fresh_base;
    end
  end

endmodule

FILE: src/stuck_condition_detector_top.sv
// Top level of the stuck condition detector: stream ports, registers, state.
// An accepted scan is held in the scan register; its result loads into the
// result register once that register is free or its result is being taken.
// Throughput: one scan per cycle while m_tready stays high. The baseline is
// written in the same cycle a scan is evaluated; no bubble for the next scan.
// Reset: synchronous; clears both stream stages, disarms the baseline and
// loads the default thresholds.
module stuck_condition_detector_top
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // Fields from bit 0: scan_fresh, auto_mode, drive_dir[2:0], front_nearest_mm,
  // contact_nearest_mm, rear_nearest_mm, left_nearest_mm, right_nearest_mm,
  // now_ms[31:0], zero fill.
  input  logic [InTdataW-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // Fields from bit 0: start_escape, surrounded, zero fill.
  output logic [OutTdataW-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data
);

  cfg_t    cfg;
  scan_t   scan;
  logic    scan_valid;
  base_t   base, base_next;
  result_t result, out_result;
  logic    fire;

  scd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scd_eval u_eval (
    .cfg       (cfg),
    .scan      (scan),
    .base      (base),
    .base_next (base_next),
    .result    (result)
  );

  // A held scan is evaluated once the result register can take its result.
  assign fire     = scan_valid && (!m_tvalid || m_tready);
  assign s_tready = !scan_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      scan_valid <= 1'b1;
    end else if (fire) begin
      scan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      scan <= s_tdata[$bits(scan_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BaseReset;
    end else if (fire) begin
      base <= base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OutTdataW-2){1'b0}}, out_result.surrounded, out_result.start_escape};

endmodule

FILE: src/scd_checker.sv
// Port-level checks for the stuck condition detector, bound to the top level.
module scd_checker
  import scd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OutTdataW-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_surrounded_implies_escape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("surrounded reported without start_escape");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutTdataW-1:2] == '0)
    else $error("result fill bits not zero");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("accepted scan did not produce a result");

endmodule

bind stuck_condition_detector_top scd_checker u_scd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/stuck_condition_detector_checker.sv
// Checker for the stuck condition detector: tracks the baseline and compares every verdict.
`timescale 1ns / 1ps
module stuck_condition_detector_checker
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [InTdataW-1:0]  s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OutTdataW-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  cfg_t    thr;
  base_t   base;
  result_t escape_verdicts[$];

  task automatic report(input string what);
    $display("ERROR at %0t ns: %s", $realtime, what);
    mismatches = mismatches + 1;
  endtask

  function automatic bit is_near(logic [DistW-1:0] d, logic [DistW-1:0] lim);
    return (d != '0) && (d <= lim);
  endfunction

  // A reading that appears or vanishes counts as a large change.
  function automatic int unsigned sector_change(logic [DistW-1:0] cur,
                                                logic [DistW-1:0] prior);
    if (cur == '0 && prior == '0) return 0;
    if (cur == '0 || prior == '0) return SectorGoneDelta;
    return (cur > prior) ? int'(cur - prior) : int'(prior - cur);
  endfunction

  function automatic base_t rebase(scan_t sc, logic [DistW-1:0] front);
    base_t b;
    b.armed      = 1'b1;
    b.base_dir   = sc.drive_dir;
    b.base_time  = sc.now_ms;
    b.base_front = front;
    b.base_rear  = sc.rear_nearest_mm;
    b.base_left  = sc.left_nearest_mm;
    b.base_right = sc.right_nearest_mm;
    return b;
  endfunction

  task automatic judge_scan(input scan_t sc, output result_t res);
    logic [DistW-1:0] front;
    logic [TimeW-1:0] age;
    int unsigned      near_cnt;
    bit               fn, rn, ln, rtn, pushing, settled, boxed;
    dir_t             dir;
    res = '0;
    dir = dir_t'(sc.drive_dir);
    if (!sc.scan_fresh || !sc.auto_mode || dir == DIR_IDLE) begin
      base = BaseReset;
      return;
    end
    front = (sc.front_nearest_mm != '0) ? sc.front_nearest_mm : sc.contact_nearest_mm;
    fn  = is_near(front, thr.near_front_mm);
    rn  = is_near(sc.rear_nearest_mm, thr.near_rear_mm);
    ln  = is_near(sc.left_nearest_mm, thr.near_side_mm);
    rtn = is_near(sc.right_nearest_mm, thr.near_side_mm);
    near_cnt = fn + rn + ln + rtn;
    if (!base.armed || base.base_dir != sc.drive_dir) begin
      base = rebase(sc, front);
      return;
    end
    age = sc.now_ms - base.base_time;
    if (age < TimeW'(thr.detect_window_ms)) return;
    pushing = ((dir == DIR_FWD || dir == DIR_ARC_L || dir == DIR_ARC_R) && fn) ||
              (dir == DIR_REV && rn);
    settled = sector_change(front, base.base_front) <= thr.change_limit_mm &&
              sector_change(sc.rear_nearest_mm, base.base_rear) <= thr.change_limit_mm &&
              sector_change(sc.left_nearest_mm, base.base_left) <= thr.change_limit_mm &&
              sector_change(sc.right_nearest_mm, base.base_right) <= thr.change_limit_mm;
    boxed = near_cnt >= BoxedCount;
    if (boxed || (pushing && settled)) begin
      res.start_escape = 1'b1;
      res.surrounded   = boxed;
      base = BaseReset;
      return;
    end
    base = rebase(sc, front);
  endtask

  always @(posedge clk) begin : monitor
    scan_t   sc;
    result_t want;
    if (rst) begin
      thr.near_front_mm    = 16'd250;
      thr.near_rear_mm     = 16'd200;
      thr.near_side_mm     = 16'd150;
      thr.change_limit_mm  = 14'd40;
      thr.detect_window_ms = 16'd1200;
      base = BaseReset;
      escape_verdicts.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NEAR_FRONT:    thr.near_front_mm    = cfg_data;
          REG_NEAR_REAR:     thr.near_rear_mm     = cfg_data;
          REG_NEAR_SIDE:     thr.near_side_mm     = cfg_data;
          REG_CHANGE_LIMIT:  thr.change_limit_mm  = cfg_data[LimitW-1:0];
          REG_DETECT_WINDOW: thr.detect_window_ms = cfg_data;
          default: ;
        endcase
      end
      // The output side is checked first: a verdict leaving now belongs to an older scan.
      if (m_tvalid && m_tready) begin
        if (escape_verdicts.size() == 0) begin
          report($sformatf("verdict 0x%0h with no scan waiting", m_tdata));
        end else begin
          want = escape_verdicts.pop_front();
          if (m_tdata[0] !== want.start_escape)
            report($sformatf("start_escape %b, expected %b", m_tdata[0], want.start_escape));
          if (m_tdata[1] !== want.surrounded)
            report($sformatf("surrounded %b, expected %b", m_tdata[1], want.surrounded));
          if (m_tdata[OutTdataW-1:2] !== '0)
            report($sformatf("fill bits 0x%0h, expected zero", m_tdata[OutTdataW-1:2]));
        end
      end
      if (s_tvalid && s_tready) begin
        sc = scan_t'(s_tdata[$bits(scan_t)-1:0]);
        judge_scan(sc, want);
        escape_verdicts.push_back(want);
      end
    end
    outstanding <= escape_verdicts.size();
  end

endmodule

FILE: verif/stuck_condition_detector_top_test.sv
// Testbench top for the stuck condition detector: clock, reset, scans, thresholds, verdict.
`timescale 1ns / 1ps
module stuck_condition_detector_top_test;
  import scd_pkg::*;

  localparam int unsigned CycleLimit   = 800000;
  localparam int unsigned RandomScans  = 1650;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgW-1:0]      cfg_data = '0;

  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;
  cfg_t live_cfg;

  stuck_condition_detector_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stuck_condition_detector_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver backpressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic scan_t mk_scan(bit fresh, bit auto_on, dir_t dir, int front, int contact,
                                    int rear, int left, int right, logic [TimeW-1:0] now);
    scan_t sc;
    sc.scan_fresh         = fresh;
    sc.auto_mode          = auto_on;
    sc.drive_dir          = dir;
    sc.front_nearest_mm   = DistW'(front);
    sc.contact_nearest_mm = DistW'(contact);
    sc.rear_nearest_mm    = DistW'(rear);
    sc.left_nearest_mm    = DistW'(left);
    sc.right_nearest_mm   = DistW'(right);
    sc.now_ms             = now;
    return sc;
  endfunction

  function automatic int clamp_dist(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Distances cluster around the threshold so both sides of it are hit often.
  function automatic int pick_dist(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 45) return (lim == 0) ? 0 : $urandom_range(1, lim);
    if (r < 55) return clamp_dist(lim + $urandom_range(0, 1));
    if (r < 85) return $urandom_range(0, 65535);
    return clamp_dist(lim + $urandom_range(1, 500));
  endfunction

  function automatic int wobble(int d, int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return clamp_dist(d + $urandom_range(0, 2 * limit) - limit);
    if (r < 85) return d;
    if (r < 93) return 0;
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [TimeW-1:0] time_step(int w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return (w == 0) ? 0 : $urandom_range(0, w - 1);
    if (r < 30) return w;
    if (r < 40) return (w == 0) ? 0 : w - 1;
    if (r < 92) return w + $urandom_range(0, w / 2 + 10);
    return $urandom;
  endfunction

  task automatic send_scan(input scan_t sc);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = (steady || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InTdataW - $bits(scan_t)){1'b0}}, sc};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending, wait until every verdict has come back, then let the bench settle.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NEAR_FRONT;
    cfg_data  <= c.near_front_mm;
    @(posedge clk);
    cfg_index <= REG_NEAR_REAR;
    cfg_data  <= c.near_rear_mm;
    @(posedge clk);
    cfg_index <= REG_NEAR_SIDE;
    cfg_data  <= c.near_side_mm;
    @(posedge clk);
    cfg_index <= REG_CHANGE_LIMIT;
    cfg_data  <= CfgW'(c.change_limit_mm);
    @(posedge clk);
    cfg_index <= REG_DETECT_WINDOW;
    cfg_data  <= c.detect_window_ms;
    @(posedge clk);
    // An index past the register list must leave every threshold alone.
    cfg_index <= CfgIdxW'($urandom_range(RegUnusedLo, RegUnusedHi));
    cfg_data  <= CfgW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    live_cfg = c;
  endtask

  initial begin : stimulus
    cfg_t              c;
    scan_t             sc;
    dir_t              dir;
    logic [TimeW-1:0]  t;
    int                sent, len, r, cl;
    int                front, contact, rear, left, right;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    live_cfg = {16'd250, 16'd200, 16'd150, 14'd40, 16'd1200};

    // Directed scans against the reset thresholds.
    send_scan(mk_scan(0, 1, DIR_FWD, 100, 0, 0, 0, 0, 10));
    send_scan(mk_scan(1, 0, DIR_FWD, 100, 0, 0, 0, 0, 20));
    send_scan(mk_scan(1, 1, DIR_IDLE, 100, 0, 0, 0, 0, 30));
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 0, 0, 1000));
    send_scan(mk_scan(1, 1, DIR_FWD, 120, 0, 0, 0, 0, 2199));
    send_scan(mk_scan(1, 1, DIR_FWD, 140, 0, 0, 0, 0, 2200));
    send_scan(mk_scan(1, 1, DIR_SPIN_L, 300, 0, 100, 100, 100, 5000));
    send_scan(mk_scan(1, 1, DIR_SPIN_L, 300, 0, 100, 100, 100, 6200));
    // Front reading missing, contact reading stands in; then a direction change.
    send_scan(mk_scan(1, 1, DIR_ARC_L, 0, 200, 0, 0, 0, 7000));
    send_scan(mk_scan(1, 1, DIR_ARC_R, 0, 200, 0, 0, 0, 9000));
    send_scan(mk_scan(1, 1, DIR_ARC_R, 0, 230, 0, 0, 0, 10200));
    send_scan(mk_scan(1, 1, DIR_REV, 900, 0, 150, 0, 0, 20000));
    send_scan(mk_scan(1, 1, DIR_REV, 900, 0, 180, 0, 0, 21500));
    // Direction code seven never pushes, but can still be boxed in.
    send_scan(mk_scan(1, 1, DIR_OTHER, 100, 0, 0, 0, 0, 30000));
    send_scan(mk_scan(1, 1, DIR_OTHER, 100, 0, 0, 0, 0, 40000));
    send_scan(mk_scan(1, 1, DIR_OTHER, 100, 0, 100, 100, 0, 50000));
    // A side reading that appears is a large change.
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 0, 0, 60000));
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 500, 0, 62000));
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 500, 0, 64000));
    send_scan(mk_scan(1, 1, DIR_SPIN_R, 100, 0, 0, 0, 0, 70000));
    send_scan(mk_scan(1, 1, DIR_SPIN_R, 100, 0, 0, 0, 0, 72000));
    // Baseline age across the wrap of the millisecond counter.
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 0, 0, 32'hFFFF_FF00));
    send_scan(mk_scan(1, 1, DIR_FWD, 100, 0, 0, 0, 0, 32'h0000_0400));
    send_scan(mk_scan(1, 1, DIR_FWD, 65535, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF));
    send_scan(mk_scan(1, 1, DIR_FWD, 65535, 65535, 65535, 65535, 65535, 32'h0000_04AF));
    settle();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 14'd9999, 16'hFFFF};
        1: c = '0;
        2: c = {16'd250, 16'd200, 16'd150, 14'd40, 16'd1200};
        default: begin
          c.near_front_mm    = DistW'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(50, 2000));
          c.near_rear_mm     = DistW'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(50, 2000));
          c.near_side_mm     = DistW'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(50, 2000));
          c.change_limit_mm  = LimitW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999)
                                                                   : $urandom_range(0, 300));
          c.detect_window_ms = DistW'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 5000));
        end
      endcase
      apply_config(c);
      cl = int'(live_cfg.change_limit_mm);

      sent = 0;
      while (sent < RandomScans / PhaseCount) begin
        steady <= ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) < 20) begin
          repeat ($urandom_range(1, 4)) begin
            sc.scan_fresh         = 1'($urandom);
            sc.auto_mode          = 1'($urandom);
            sc.drive_dir          = DirW'($urandom_range(0, 7));
            sc.front_nearest_mm   = DistW'($urandom);
            sc.contact_nearest_mm = DistW'($urandom);
            sc.rear_nearest_mm    = DistW'($urandom);
            sc.left_nearest_mm    = DistW'($urandom);
            sc.right_nearest_mm   = DistW'($urandom);
            sc.now_ms             = $urandom;
            send_scan(sc);
            sent++;
          end
        end else begin
          // A run of scans in one direction with slowly varying distances.
          dir = ($urandom_range(0, 99) < 70) ? dir_t'($urandom_range(1, 4))
                                             : dir_t'($urandom_range(5, 7));
          t       = $urandom;
          front   = pick_dist(live_cfg.near_front_mm);
          contact = pick_dist(live_cfg.near_front_mm);
          rear    = pick_dist(live_cfg.near_rear_mm);
          left    = pick_dist(live_cfg.near_side_mm);
          right   = pick_dist(live_cfg.near_side_mm);
          len     = $urandom_range(2, 7);
          for (int k = 0; k < len; k++) begin
            if (k > 0) begin
              t       = t + time_step(live_cfg.detect_window_ms);
              front   = wobble(front, cl);
              contact = wobble(contact, cl);
              rear    = wobble(rear, cl);
              left    = wobble(left, cl);
              right   = wobble(right, cl);
            end
            sc = mk_scan(1, 1, dir, front, contact, rear, left, right, t);
            r = $urandom_range(0, 99);
            if (r < 2) sc.scan_fresh = 1'b0;
            else if (r < 4) sc.auto_mode = 1'b0;
            else if (r < 5) sc.drive_dir = DIR_IDLE;
            else if (r < 7) sc.drive_dir = DirW'($urandom_range(1, 7));
            send_scan(sc);
            sent++;
          end
        end
        if ($urandom_range(0, 99) < 3) settle();
      end
      steady <= 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
